// ----- hdl/rlt_pkg.sv -----
// ----------------------------------------------------------------------------
// Reentrant lock table package
// Command and status codes, default sizes and the controller/datapath
// interface types shared by the lock table modules.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // Default sizes for the top-level parameters.
  localparam int LOCK_SLOTS_DEF = 64;
  localparam int TASK_COUNT_DEF = 32;
  localparam int COUNT_BITS_DEF = 8;

  // Fixed field widths of the command and result beats.
  localparam int CMD_W     = 3;
  localparam int LOCK_ID_W = 6;
  localparam int TASK_ID_W = 5;
  localparam int STATUS_W  = 3;
  localparam int WOKEN_W   = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TRY_LOCK      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DESTROY       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD_WAITER    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE_WAITER = 3'd5;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACQUIRED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted command and read its slot
    logic commit;   // update the slot and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // result register holds a beat that is not taken
  } dp_status_t;

endpackage

// ----- hdl/rlt_controller.sv -----
// ----------------------------------------------------------------------------
// Reentrant lock table controller
// Two-state sequencer: accept a command beat, then commit it once the
// result register is free.
// ----------------------------------------------------------------------------
module rlt_controller
  import rlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t dps,
  output ctl_cmd_t   ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Handshake and datapath commands.
  assign in_ready    = (state == S_IDLE);
  assign ctl.capture = in_valid && (state == S_IDLE);
  assign ctl.commit  = (state == S_EXEC) && !dps.out_busy;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!dps.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/rlt_datapath.sv -----
// ----------------------------------------------------------------------------
// Reentrant lock table datapath
// In-use flags, slot memory, free-slot search, per-command slot update and
// the result register.
// ----------------------------------------------------------------------------
module rlt_datapath
  import rlt_pkg::*;
#(
  parameter int LOCK_SLOTS = LOCK_SLOTS_DEF,
  parameter int TASK_COUNT = TASK_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             ctl,
  output dp_status_t           dps,
  input  logic [CMD_W-1:0]     command,
  input  logic [LOCK_ID_W-1:0] lock_id,
  input  logic [TASK_ID_W-1:0] task_id,
  input  logic                 reentrant_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [LOCK_ID_W-1:0] new_lock,
  output logic [WOKEN_W-1:0]   woken_tasks
);

  // Only slots that the lock id field can address are ever used.
  localparam int ADDRESSABLE = 1 << LOCK_ID_W;
  localparam int SLOTS  = (LOCK_SLOTS < ADDRESSABLE) ? LOCK_SLOTS : ADDRESSABLE;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int VIS    = (TASK_COUNT < WOKEN_W) ? TASK_COUNT : WOKEN_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                  reentrant;
    logic [COUNT_BITS-1:0] count;
    logic [TASK_ID_W-1:0]  owner;
    logic [TASK_COUNT-1:0] waiters;
  } entry_t;

  logic [SLOTS-1:0]  in_use;
  entry_t            mem [SLOTS];
  entry_t            rd_entry;

  logic [CMD_W-1:0]     cmd_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [TASK_ID_W-1:0] task_q;
  logic                 mode_q;
  logic                 known_q;
  logic                 free_found_q;
  logic [SLOT_W-1:0]    free_idx_q;

  logic [SLOTS-1:0]  free_vec;
  logic [SLOTS-1:0]  free_low;
  logic [SLOT_W-1:0] free_idx;
  logic              known;

  entry_t                entry_next;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [STATUS_W-1:0]   status_next;
  logic [LOCK_ID_W-1:0]  new_lock_next;
  logic [TASK_COUNT-1:0] woken_bm;
  logic [WOKEN_W-1:0]    woken_next;
  logic [TASK_COUNT-1:0] task_bit;
  logic                  task_ok;
  logic                  slot_cmd;
  logic                  release_partial;

  // Lookup of the addressed slot and the lowest free slot.
  always_comb begin
    known    = (int'(lock_id) < SLOTS) && in_use[lock_id[SLOT_W-1:0]];
    free_vec = ~in_use;
    free_low = free_vec & (~free_vec + SLOTS'(1));
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_low[i]) free_idx = free_idx | SLOT_W'(i);
    end
  end

  // Command capture at the accepting edge.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q        <= command;
      idx_q        <= lock_id[SLOT_W-1:0];
      task_q       <= task_id;
      mode_q       <= reentrant_mode;
      known_q      <= known;
      free_found_q <= |free_vec;
      free_idx_q   <= free_idx;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.commit && wr_en) mem[wr_addr] <= entry_next;
    if (ctl.capture) rd_entry <= mem[lock_id[SLOT_W-1:0]];
  end

  // Slot update and result for the captured command.
  always_comb begin
    entry_next      = rd_entry;
    wr_en           = 1'b0;
    wr_addr         = idx_q;
    status_next     = ST_REFUSED;
    new_lock_next   = '0;
    woken_bm        = '0;
    task_bit        = TASK_COUNT'(1) << task_q;
    task_ok         = int'(task_q) < TASK_COUNT;
    slot_cmd        = (cmd_q >= CMD_TRY_LOCK) && (cmd_q <= CMD_REMOVE_WAITER);
    release_partial = rd_entry.reentrant && (rd_entry.count > COUNT_BITS'(1));

    if (cmd_q == CMD_CREATE) begin
      if (free_found_q) begin
        entry_next.reentrant = mode_q;
        entry_next.count     = '0;
        entry_next.owner     = '0;
        entry_next.waiters   = '0;
        wr_en                = 1'b1;
        wr_addr              = free_idx_q;
        status_next          = ST_DONE;
        new_lock_next        = LOCK_ID_W'(free_idx_q);
      end else begin
        status_next = ST_FULL;
      end
    end else if (slot_cmd && !known_q) begin
      status_next = ST_UNKNOWN;
    end else begin
      case (cmd_q)
        CMD_TRY_LOCK: begin
          if (rd_entry.count == '0) begin
            entry_next.count = COUNT_BITS'(1);
            entry_next.owner = rd_entry.reentrant ? task_q : '0;
            wr_en            = 1'b1;
            status_next      = ST_ACQUIRED;
          end else if (rd_entry.reentrant && (rd_entry.owner == task_q) &&
                       (rd_entry.count != COUNT_MAX)) begin
            entry_next.count = rd_entry.count + COUNT_BITS'(1);
            wr_en            = 1'b1;
            status_next      = ST_ACQUIRED;
          end
        end
        CMD_UNLOCK: begin
          if (release_partial) begin
            entry_next.count = rd_entry.count - COUNT_BITS'(1);
          end else begin
            entry_next.count   = '0;
            entry_next.owner   = '0;
            entry_next.waiters = '0;
            woken_bm           = rd_entry.waiters;
          end
          wr_en       = 1'b1;
          status_next = ST_DONE;
        end
        CMD_DESTROY: begin
          // The release of the final hold wakes the waiters; the slot is then freed.
          if (!release_partial) woken_bm = rd_entry.waiters;
          entry_next  = '0;
          wr_en       = 1'b1;
          status_next = ST_DONE;
        end
        CMD_ADD_WAITER: begin
          if (task_ok) entry_next.waiters = rd_entry.waiters | task_bit;
          wr_en       = 1'b1;
          status_next = ST_DONE;
        end
        CMD_REMOVE_WAITER: begin
          if (task_ok) entry_next.waiters = rd_entry.waiters & ~task_bit;
          wr_en       = 1'b1;
          status_next = ST_DONE;
        end
        default: begin
          status_next = ST_REFUSED;
        end
      endcase
    end

    // Only the low waiter bits are visible in the result.
    woken_next          = '0;
    woken_next[VIS-1:0] = woken_bm[VIS-1:0];
  end

  // In-use flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (ctl.commit) begin
      if ((cmd_q == CMD_CREATE) && free_found_q) in_use[free_idx_q] <= 1'b1;
      if ((cmd_q == CMD_DESTROY) && known_q) in_use[idx_q] <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status      <= status_next;
      new_lock    <= new_lock_next;
      woken_tasks <= woken_next;
    end
  end

  assign dps.out_busy = out_valid && !out_ready;

endmodule

// ----- hdl/reentrant_lock_table_top.sv -----
// ----------------------------------------------------------------------------
// Reentrant lock table
// Table of lock slots with create, try-lock, unlock, destroy and waiter
// bookkeeping; one result beat for every command beat.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  command   in_valid / in_ready   command, lock_id, task_id, reentrant_mode
//  result    out_valid / out_ready status, new_lock, woken_tasks
//
// The accepting edge latches a command beat and reads the slot memory; the commit
// step then updates the slot and loads the result register.
// A new command is accepted while an earlier result still waits to be taken.
// A stalled result holds the command in its update step until the register frees.
// Reset clears the in-use flags, the result valid flag and the sequencer state;
// slot memory needs no clearing pass, since a slot is rewritten when it is created.
module reentrant_lock_table_top
  import rlt_pkg::*;
#(
  parameter int LOCK_SLOTS = LOCK_SLOTS_DEF,
  parameter int TASK_COUNT = TASK_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [LOCK_ID_W-1:0] lock_id,
  input  logic [TASK_ID_W-1:0] task_id,
  input  logic                 reentrant_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [LOCK_ID_W-1:0] new_lock,
  output logic [WOKEN_W-1:0]   woken_tasks
);

  ctl_cmd_t   ctl;
  dp_status_t dps;

  // Sequencer.
  rlt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dps      (dps),
    .ctl      (ctl)
  );

  // Slot storage and update logic.
  rlt_datapath #(
    .LOCK_SLOTS (LOCK_SLOTS),
    .TASK_COUNT (TASK_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .dps            (dps),
    .command        (command),
    .lock_id        (lock_id),
    .task_id        (task_id),
    .reentrant_mode (reentrant_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .new_lock       (new_lock),
    .woken_tasks    (woken_tasks)
  );

`ifndef SYNTH
  // A commit never coincides with accepting a new command.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctl.commit && in_valid && in_ready))
    else $error("commit overlaps command accept");

  // An accepted command blocks the input for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // A commit always presents a result beat.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> out_valid)
    else $error("commit without result beat");

  // A full table gives no slot number.
  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (new_lock == '0))
    else $error("full result carries a slot number");

  // Only completed commands can report woken tasks.
  a_woken_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DONE)) |-> (woken_tasks == '0))
    else $error("woken tasks on a non-done result");
`endif

endmodule
